// File: hdl/range_max_segment_tree_defines.svh
// Assertion macros shared by the range maximum segment tree modules.
`ifndef RANGE_MAX_SEGMENT_TREE_DEFINES_SVH
`define RANGE_MAX_SEGMENT_TREE_DEFINES_SVH

// Same-cycle implication, checked on clock, disabled in reset.
`define RMST_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication, checked on clock, disabled in reset.
`define RMST_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// File: hdl/rmst_pkg.sv
// Types, constants and helpers of the range maximum segment tree.
package rmst_pkg;

   localparam int LEAVES      = 1024;
   localparam int NODES       = 2 * LEAVES;
   localparam int NODE_W      = $clog2(NODES);
   localparam int HI_W        = $clog2(NODES + 1);
   localparam int VAL_W       = 32;
   localparam int POS_W       = 10;
   localparam int END_W       = 11;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [VAL_W-1:0] value_type;

   localparam value_type MIN_VALUE = {1'b1, {(VAL_W-1){1'b0}}};

   typedef enum logic {
      OP_UPDATE = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      B_CLEAR,
      B_IDLE,
      B_UPD,
      B_QRY
   } back_state_type;

   // Classified item as it travels from front to back; lo/hi are node indexes.
   typedef struct packed {
      op_type           op;
      logic [HI_W-1:0]  lo;
      logic [HI_W-1:0]  hi;
      value_type        value;
   } cmd_type;

   typedef struct packed {
      logic clearing;
      logic full;
   } front_ctl_type;

   function automatic value_type smax(input value_type a, input value_type b);
      return (a >= b) ? a : b;
   endfunction

endpackage

// File: hdl/rmst_channels.sv
// Handshake channel interfaces for requests and responses.
interface rmst_req_if
   import rmst_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                req_type;
   logic [POS_W-1:0]    position;
   logic [END_W-1:0]    range_end;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, req_type, position, range_end, value, input ready);
   modport sink   (input valid, req_type, position, range_end, value, output ready);
endinterface

interface rmst_rsp_if
   import rmst_pkg::*;
();
   logic                valid;
   logic                ready;
   logic signed [VAL_W-1:0] max_value;
   logic                range_empty;

   modport source (output valid, max_value, range_empty, input ready);
   modport sink   (input valid, max_value, range_empty, output ready);
endinterface

// File: hdl/rmst_front.sv
// Front end: accepts request items, drops invalid updates, clamps query ranges.
module rmst_front
   import rmst_pkg::*;
(
   rmst_req_if.sink      req_ch,
   input  front_ctl_type ctl,
   output logic          push,
   output cmd_type       push_cmd
);

   logic              leaf_ok;
   logic [END_W-1:0]  end_sat;
   op_type            op;

   always_comb begin
      op       = op_type'(req_ch.req_type);
      leaf_ok  = int'(req_ch.position) < LEAVES;
      end_sat  = (int'(req_ch.range_end) > LEAVES) ? END_W'(LEAVES) : req_ch.range_end;

      req_ch.ready = !ctl.clearing && !ctl.full;
      // out-of-range updates are swallowed here and never reach the queue
      push = req_ch.valid && req_ch.ready && ((op == OP_QUERY) || leaf_ok);

      push_cmd.op    = op;
      push_cmd.lo    = HI_W'(LEAVES) + HI_W'(req_ch.position);
      push_cmd.hi    = HI_W'(LEAVES) + HI_W'(end_sat);
      push_cmd.value = req_ch.value;
   end

endmodule

// File: hdl/rmst_queue.sv
// Short command queue between front and back end.
module rmst_queue
   import rmst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output cmd_type head
);

`include "range_max_segment_tree_defines.svh"

   cmd_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `RMST_ASSERT_IMP(a_no_push_full, full, !push)
   `RMST_ASSERT_IMP(a_no_pop_empty, !not_empty, !pop)

endmodule

// File: hdl/rmst_back.sv
// Back end: node memory, clearing sweep, update and query tree walks, result register.
module rmst_back
   import rmst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  cmd_type     q_head,
   output logic        q_pop,
   output logic        clearing,
   rmst_rsp_if.source  rsp_ch
);

`include "range_max_segment_tree_defines.svh"

   back_state_type    state_ff, state_in;
   logic [HI_W-1:0]   lo_ff, lo_in;
   logic [HI_W-1:0]   hi_ff, hi_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   value_type         cur_ff, cur_in;
   value_type         best_ff, best_in;
   logic              found_ff, found_in;
   logic              pend_ff, pend_in;
   logic              plo_ff, plo_in;
   logic              phi_ff, phi_in;
   logic              rsp_valid_ff, rsp_valid_in;
   value_type         rsp_max_ff, rsp_max_in;
   logic              rsp_empty_ff, rsp_empty_in;

   value_type         mem [NODES];
   value_type         rd0_ff, rd1_ff;
   logic              wr_en;
   logic [NODE_W-1:0] wr_addr;
   value_type         wr_data;
   logic [NODE_W-1:0] rd0_addr, rd1_addr;

   logic [HI_W-1:0]   up;
   logic [HI_W-1:0]   hi_m1;
   value_type         parent;
   value_type         merge_best;
   logic              merge_found;

   assign clearing = (state_ff == B_CLEAR);
   assign up       = lo_ff >> 1;
   assign hi_m1    = hi_ff - HI_W'(1);
   assign parent   = smax(cur_ff, rd0_ff);

   // fold in the node reads issued on the previous query step
   always_comb begin
      merge_best  = best_ff;
      merge_found = found_ff;
      if (pend_ff && plo_ff) begin
         merge_best  = merge_found ? smax(merge_best, rd0_ff) : rd0_ff;
         merge_found = 1'b1;
      end
      if (pend_ff && phi_ff) begin
         merge_best  = merge_found ? smax(merge_best, rd1_ff) : rd1_ff;
         merge_found = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      best_in      = best_ff;
      found_in     = found_ff;
      pend_in      = pend_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_max_in   = rsp_max_ff;
      rsp_empty_in = rsp_empty_ff;
      wr_en        = 1'b0;
      wr_addr      = clr_ff;
      wr_data      = '0;
      rd0_addr     = lo_ff[NODE_W-1:0];
      rd1_addr     = hi_m1[NODE_W-1:0];
      q_pop        = 1'b0;

      case (state_ff)
         B_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + NODE_W'(1);
            if (clr_ff == NODE_W'(NODES-1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               lo_in = q_head.lo;
               hi_in = q_head.hi;
               if (q_head.op == OP_UPDATE) begin
                  // write the leaf, fetch its sibling
                  wr_en    = 1'b1;
                  wr_addr  = q_head.lo[NODE_W-1:0];
                  wr_data  = q_head.value;
                  rd0_addr = q_head.lo[NODE_W-1:0] ^ NODE_W'(1);
                  cur_in   = q_head.value;
                  state_in = B_UPD;
               end else begin
                  best_in  = '0;
                  found_in = 1'b0;
                  pend_in  = 1'b0;
                  state_in = B_QRY;
               end
            end
         end
         B_UPD: begin
            // one level per cycle: write parent, fetch parent's sibling
            wr_en    = 1'b1;
            wr_addr  = up[NODE_W-1:0];
            wr_data  = parent;
            cur_in   = parent;
            lo_in    = up;
            rd0_addr = up[NODE_W-1:0] ^ NODE_W'(1);
            if (up == HI_W'(1)) begin
               state_in = B_IDLE;
            end
         end
         B_QRY: begin
            best_in  = merge_best;
            found_in = merge_found;
            if (lo_ff < hi_ff) begin
               plo_in  = lo_ff[0];
               phi_in  = hi_ff[0];
               pend_in = 1'b1;
               lo_in   = (lo_ff + HI_W'(lo_ff[0])) >> 1;
               hi_in   = hi_ff >> 1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff && (!rsp_valid_ff || rsp_ch.ready)) begin
                  rsp_valid_in = 1'b1;
                  rsp_max_in   = found_ff ? best_ff : MIN_VALUE;
                  rsp_empty_in = !found_ff;
                  state_in     = B_IDLE;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      cur_ff       <= cur_in;
      best_ff      <= best_in;
      found_ff     <= found_in;
      plo_ff       <= plo_in;
      phi_ff       <= phi_in;
      rsp_max_ff   <= rsp_max_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd0_ff <= mem[rd0_addr];
      rd1_ff <= mem[rd1_addr];
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.max_value   = rsp_max_ff;
   assign rsp_ch.range_empty = rsp_empty_ff;

   `RMST_ASSERT_IMP(a_pop_only_idle, q_pop, state_ff == B_IDLE)
   `RMST_ASSERT_IMP(a_upd_below_root, state_ff == B_UPD, lo_ff > HI_W'(1))
   `RMST_ASSERT_IMP(a_pend_in_query, pend_ff, state_ff == B_QRY)
   `RMST_ASSERT_IMP(a_empty_gives_min, rsp_valid_ff && rsp_empty_ff, rsp_max_ff == MIN_VALUE)

endmodule

// File: hdl/range_max_segment_tree.sv
// Range maximum segment tree: channel wiring of front end, queue and back end.
//
// Request channel req_ch: req_type 0 writes value into leaf position and
// recomputes every ancestor; req_type 1 asks for the maximum over leaves
// [position, range_end). Updates give no response; each query gives one
// item on rsp_ch with max_value and range_empty (empty range: most negative
// value, flag set). range_end above the leaf count is clamped.
// Items are classified and queued (two entries) the cycle they are taken,
// so requests keep flowing while a response waits on a stalled receiver.
// The back end owns a 2048-entry node memory (one write, two reads per cycle)
// and walks one tree level per cycle: an update writes the leaf and then each
// ancestor up to the root; a query folds in node reads level by level and
// registers its response once the response register is free. The level walk through the memory sets this pace.
// Reset is synchronous; afterwards a clearing sweep writes zero into all
// 2048 nodes, one per cycle, and req_ch.ready stays low during the sweep.
// A response waits in its register until rsp_ch.ready; a later query that
// finishes meanwhile holds the back end until then, and the queue then
// fills and deasserts req_ch.ready.
module range_max_segment_tree
   import rmst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   rmst_req_if.sink   req_ch,
   rmst_rsp_if.source rsp_ch
);

   logic          push;
   cmd_type       push_cmd;
   logic          q_full;
   logic          q_valid;
   cmd_type       q_head;
   logic          q_pop;
   logic          clearing;
   front_ctl_type ctl;

   assign ctl.clearing = clearing;
   assign ctl.full     = q_full;

   rmst_front u_front (
      .req_ch   (req_ch),
      .ctl      (ctl),
      .push     (push),
      .push_cmd (push_cmd)
   );

   rmst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head      (q_head)
   );

   rmst_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .clearing (clearing),
      .rsp_ch   (rsp_ch)
   );

endmodule
